>>> hdl/spbq_pkg.sv
// Package for the strict-priority byte queue: sizes, codes, command type.
// No dependencies.
package spbq_pkg;
   localparam int MaxClasses      = 8;
   localparam int EntriesPerClass = 64;
   localparam int TagBits         = 16;
   localparam int ClassBits       = (MaxClasses > 1) ? $clog2(MaxClasses) : 1;
   localparam int PtrBits         = $clog2(EntriesPerClass);
   localparam int CountBits       = $clog2(EntriesPerClass + 1);
   localparam int StoreDepth      = MaxClasses * EntriesPerClass;
   localparam int AddrBits        = $clog2(StoreDepth);
   localparam int ByteBits        = 32;
   localparam int NqBits          = $clog2(MaxClasses + 1);

   localparam logic [2:0] ST_QUEUED   = 3'd0;
   localparam logic [2:0] ST_OVER     = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_BADCLASS = 3'd3;
   localparam logic [2:0] ST_MARKERR  = 3'd4;
   localparam logic [2:0] ST_DEQUEUED = 3'd5;
   localparam logic [2:0] ST_EMPTY    = 3'd6;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [2:0] REG_NUM_QUEUES = 3'd0;
   localparam logic [2:0] REG_QLIMIT     = 3'd1;
   localparam logic [2:0] REG_MEAN       = 3'd2;
   localparam logic [2:0] REG_THRESH     = 3'd3;
   localparam logic [2:0] REG_MARKMODE   = 3'd4;

   localparam logic [1:0] MARK_QUEUE = 2'd1;
   localparam logic [1:0] MARK_PORT  = 2'd2;

   typedef struct packed {
      logic operation;
      logic [3:0] priority_req;
      logic [15:0] pkt_bytes;
      logic [15:0] pkt_tag;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [15:0] out_tag;
      logic [2:0] out_priority;
      logic [15:0] out_bytes;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request and its decision
      logic commit;   // apply decision, read store data, build result
   } cmd_type;
endpackage

>>> hdl/spbq_if.sv
// Valid/ready channel interface for request and result beats.
// Depends on spbq_pkg.
interface spbq_req_if;
   import spbq_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface spbq_rsp_if;
   import spbq_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hdl/strict_priority_byte_queue_core.sv
// Top level of the strict-priority byte queue: channels, CSR block, controller, datapath.
// Depends on spbq_pkg, spbq_if, spbq_ctrl, spbq_dp.
//
// Usage:
//   req channel: one beat per packet operation (enqueue or dequeue).
//   rsp channel: exactly one result beat per request beat, in order.
//   csr port: APB-style writes to num_queues, queue_limit_pkts, mean_pkt_bytes,
//   mark_threshold_pkts, marking_mode at byte addresses 0,4,8,12,16.
// Each accepted beat passes through the EXEC state; its result is registered
//   and shown valid in the HOLD state.
// Operations do not overlap: the byte counters and FIFO pointers are read,
//   decided on, then written back before the next beat is taken.
// The result register holds while rsp_ready is low; a new beat is taken in
//   the same cycle the held result drains.
// Reset clears all pointers, counts and byte totals; the descriptor memory
//   is not cleared and only written entries are ever returned.
module strict_priority_byte_queue_core (
   input  logic clock,
   input  logic reset,
   spbq_req_if.sink   req,
   spbq_rsp_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import spbq_pkg::*;

   logic [3:0]  num_queues_ff;
   logic [15:0] qlimit_ff;
   logic [13:0] mean_ff;
   logic [15:0] thresh_ff;
   logic [1:0]  markmode_ff;
   logic [2:0]  reg_idx;
   logic        csr_wr;
   cmd_type cmd;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[4:2];
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   // write registers at the access edge
   always_ff @(posedge clock) begin
      if (reset) begin
         num_queues_ff <= 4'd8;
         qlimit_ff <= 16'd100;
         mean_ff <= 14'd1500;
         thresh_ff <= 16'hFFFF;
         markmode_ff <= 2'd0;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_NUM_QUEUES: num_queues_ff <= csr_pwdata[3:0];
            REG_QLIMIT:     qlimit_ff <= csr_pwdata[15:0];
            REG_MEAN:       mean_ff <= csr_pwdata[13:0];
            REG_THRESH:     thresh_ff <= csr_pwdata[15:0];
            REG_MARKMODE:   markmode_ff <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_NUM_QUEUES: csr_prdata = {28'd0, num_queues_ff};
         REG_QLIMIT:     csr_prdata = {16'd0, qlimit_ff};
         REG_MEAN:       csr_prdata = {18'd0, mean_ff};
         REG_THRESH:     csr_prdata = {16'd0, thresh_ff};
         REG_MARKMODE:   csr_prdata = {30'd0, markmode_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // sequence each beat through decide and commit
   spbq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd)
   );

   spbq_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req(req.data), .rsp(rsp.data),
      .num_queues(num_queues_ff), .queue_limit_pkts(qlimit_ff),
      .mean_pkt_bytes(mean_ff), .mark_threshold_pkts(thresh_ff),
      .marking_mode(markmode_ff)
   );
endmodule

>>> hdl/spbq_ctrl.sv
// Controller: accepts a beat, sequences decision and commit, holds the result.
// Depends on spbq_pkg.
module spbq_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output spbq_pkg::cmd_type cmd
);
   import spbq_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HOLD} state_type;
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // take a new beat when the result slot is free or draining this cycle
   assign req_ready = (state_ff == S_IDLE) || (state_ff == S_HOLD && rsp_ready);
   assign cmd.load = req_valid && req_ready;
   assign cmd.commit = (state_ff == S_EXEC);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_HOLD;
            rsp_valid_in = 1'b1;
         end
         S_HOLD: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = req_valid ? S_EXEC : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

>>> hdl/spbq_dp.sv
// Datapath: class FIFO pointers, byte counters, descriptor memory, result register.
// Depends on spbq_pkg.
module spbq_dp (
   input  logic clock,
   input  logic reset,
   input  spbq_pkg::cmd_type cmd,
   input  spbq_pkg::req_type req,
   output spbq_pkg::rsp_type rsp,
   input  logic [3:0] num_queues,
   input  logic [15:0] queue_limit_pkts,
   input  logic [13:0] mean_pkt_bytes,
   input  logic [15:0] mark_threshold_pkts,
   input  logic [1:0] marking_mode
);
   import spbq_pkg::*;

   logic [PtrBits-1:0]   head_ff [MaxClasses];
   logic [PtrBits-1:0]   tail_ff [MaxClasses];
   logic [CountBits-1:0] count_ff [MaxClasses];
   logic [ByteBits-1:0]  cbytes_ff [MaxClasses];
   logic [ByteBits-1:0]  total_ff;
   logic [31:0]          mem [StoreDepth];
   logic [31:0]          rd_ff;

   req_type req_ff;
   logic [2:0] status_ff;
   logic [ClassBits-1:0] cls_ff;
   logic [ByteBits-1:0] thr_ff;
   logic do_enq_ff, do_deq_ff;

   // stage 1: decide from current state
   logic [NqBits-1:0] nq;
   logic [ByteBits:0] limit, lhs;
   logic [ByteBits+5:0] lim24, lhs25;
   logic over;
   logic [ClassBits-1:0] sel;
   logic found;
   logic [2:0] st1;
   logic [ClassBits-1:0] pcls;

   always_comb begin
      if (num_queues == 4'd0) nq = NqBits'(1);
      else if (32'(num_queues) > MaxClasses) nq = NqBits'(MaxClasses);
      else nq = NqBits'(num_queues);
      limit = (ByteBits+1)'(queue_limit_pkts * 30'(mean_pkt_bytes));
      // shared part: lhs > floor(limit*24/25) exactly when 25*lhs > 24*limit
      lim24 = ({5'd0, limit} << 4) + ({5'd0, limit} << 3);
      pcls = ClassBits'(req.priority_req);
      if (req.priority_req == 4'd0)
         lhs = {1'b0, total_ff} + (ByteBits+1)'(req.pkt_bytes);
      else
         lhs = {1'b0, total_ff - cbytes_ff[0]} + (ByteBits+1)'(req.pkt_bytes);
      lhs25 = ({5'd0, lhs} << 4) + ({5'd0, lhs} << 3) + {5'd0, lhs};
      over = (req.priority_req == 4'd0) ? (lhs > limit) : (lhs25 > lim24);
      found = 1'b0;
      sel = '0;
      for (int i = 0; i < MaxClasses; i++) begin
         if (i < 32'(nq) && count_ff[i] != '0) begin
            found = 1'b1;
            sel = ClassBits'(i);
         end
      end
      if (req.operation == OP_DEQ) st1 = found ? ST_DEQUEUED : ST_EMPTY;
      else if (over) st1 = ST_OVER;
      else if (5'(req.priority_req) >= 5'(nq)) st1 = ST_BADCLASS;
      else if (32'(count_ff[pcls]) >= EntriesPerClass) st1 = ST_FULL;
      else st1 = ST_QUEUED;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         status_ff <= st1;
         cls_ff <= (req.operation == OP_DEQ) ? sel : pcls;
         thr_ff <= ByteBits'(mark_threshold_pkts * 30'(mean_pkt_bytes));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         do_enq_ff <= 1'b0;
         do_deq_ff <= 1'b0;
      end else begin
         do_enq_ff <= cmd.load && req.operation == OP_ENQ && st1 == ST_QUEUED;
         do_deq_ff <= cmd.load && st1 == ST_DEQUEUED;
      end
   end

   // memory read in stage 1 (registered), write in stage 2
   always_ff @(posedge clock) begin
      rd_ff <= mem[{sel, head_ff[sel]}];
      if (do_enq_ff)
         mem[{cls_ff, tail_ff[cls_ff]}] <= {TagBits'(req_ff.pkt_tag), req_ff.pkt_bytes};
   end

   logic [ByteBits-1:0] new_cb, new_tot;
   logic [15:0] rb;
   logic mark;
   always_comb begin
      rb = rd_ff[15:0];
      new_cb = cbytes_ff[cls_ff] + ByteBits'(req_ff.pkt_bytes);
      new_tot = total_ff + ByteBits'(req_ff.pkt_bytes);
      mark = (marking_mode == MARK_QUEUE && new_cb > thr_ff) ||
             (marking_mode == MARK_PORT && new_tot > thr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxClasses; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            count_ff[i] <= '0;
            cbytes_ff[i] <= '0;
         end
         total_ff <= '0;
      end else if (do_enq_ff) begin
         tail_ff[cls_ff] <= (32'(tail_ff[cls_ff]) == EntriesPerClass - 1) ? '0
                            : tail_ff[cls_ff] + PtrBits'(1);
         count_ff[cls_ff] <= count_ff[cls_ff] + CountBits'(1);
         cbytes_ff[cls_ff] <= new_cb;
         total_ff <= new_tot;
      end else if (do_deq_ff) begin
         head_ff[cls_ff] <= (32'(head_ff[cls_ff]) == EntriesPerClass - 1) ? '0
                            : head_ff[cls_ff] + PtrBits'(1);
         count_ff[cls_ff] <= count_ff[cls_ff] - CountBits'(1);
         cbytes_ff[cls_ff] <= cbytes_ff[cls_ff] - ByteBits'(rb);
         total_ff <= total_ff - ByteBits'(rb);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp.status <= (do_enq_ff && mark) ? ST_MARKERR : status_ff;
         rsp.out_tag <= do_deq_ff ? 16'(rd_ff[31:16]) : 16'd0;
         rsp.out_priority <= do_deq_ff ? 3'(cls_ff) : 3'd0;
         rsp.out_bytes <= do_deq_ff ? rb : 16'd0;
      end
   end
endmodule

>>> hdl/spbq_checker.sv
// Port-level checker for the strict-priority byte queue, bound to the top level.
// Depends on spbq_pkg and strict_priority_byte_queue_core.
module spbq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status,
   input logic [15:0] rsp_bytes
);
   import spbq_pkg::*;

   // a taken beat passes through EXEC; its result is then valid in HOLD
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ##1 rsp_valid) else $error("no result");
   // no new beat while a result is stuck
   a_noaccept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready) else $error("accept on stall");
   // only dequeued results carry bytes
   a_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DEQUEUED) |-> rsp_bytes == 16'd0)
      else $error("bytes");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status))
      else $error("hold");
endmodule

bind strict_priority_byte_queue_core spbq_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.data.status), .rsp_bytes(rsp.data.out_bytes)
);

>>> bench/testbench.sv
// Self-checking bench for strict_priority_byte_queue_core: predicts every status
// beat from its own queue model and compares field by field.
// Depends on spbq_pkg, spbq_if and the core RTL.
`timescale 1ns / 1ps

module testbench;
   import spbq_pkg::*;

   localparam int TimeoutCycles = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   spbq_req_if req_ch ();
   spbq_rsp_if rsp_ch ();

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   strict_priority_byte_queue_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch.sink),
      .rsp        (rsp_ch.source),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Queue shadow: configuration and per-class descriptor FIFOs.
   logic [3:0]  cfg_nq;
   logic [15:0] cfg_qlim;
   logic [13:0] cfg_mean;
   logic [15:0] cfg_thresh;
   logic [1:0]  cfg_mark;

   logic [15:0] fifo_tag [MaxClasses][$];
   logic [15:0] fifo_len [MaxClasses][$];
   longint      class_sum [MaxClasses];
   longint      port_sum;

   req_type pending_beats [$];
   rsp_type expected_status [$];

   int mismatches = 0;
   int cycles = 0;
   bit long_holdoff = 1'b0;

   function automatic rsp_type queue_predict(req_type r);
      rsp_type res;
      int      nq;
      longint  limit, shared, thr;
      bit      over, found;
      int      c;
      res = '0;
      nq = (cfg_nq < 1) ? 1 : ((cfg_nq > MaxClasses) ? MaxClasses : cfg_nq);
      if (r.operation == OP_ENQ) begin
         limit  = longint'(cfg_qlim) * longint'(cfg_mean);
         shared = (limit * 24) / 25;
         // admission check runs ahead of the class check
         if (r.priority_req == 0)
            over = port_sum + r.pkt_bytes > limit;
         else
            over = (port_sum - class_sum[0]) + r.pkt_bytes > shared;
         if (over)
            res.status = ST_OVER;
         else if (r.priority_req >= nq)
            res.status = ST_BADCLASS;
         else if (fifo_tag[r.priority_req].size() >= EntriesPerClass)
            res.status = ST_FULL;
         else begin
            c = r.priority_req;
            thr = longint'(cfg_thresh) * longint'(cfg_mean);
            fifo_tag[c].push_back(r.pkt_tag);
            fifo_len[c].push_back(r.pkt_bytes);
            class_sum[c] += r.pkt_bytes;
            port_sum += r.pkt_bytes;
            if ((cfg_mark == MARK_QUEUE && class_sum[c] > thr) ||
                (cfg_mark == MARK_PORT && port_sum > thr))
               res.status = ST_MARKERR;
            else
               res.status = ST_QUEUED;
         end
      end else begin
         found = 1'b0;
         for (int i = nq - 1; i >= 0; i--) begin
            if (!found && fifo_tag[i].size() > 0) begin
               res.out_tag = fifo_tag[i].pop_front();
               res.out_bytes = fifo_len[i].pop_front();
               res.out_priority = i[2:0];
               class_sum[i] -= res.out_bytes;
               port_sum -= res.out_bytes;
               found = 1'b1;
            end
         end
         res.status = found ? ST_DEQUEUED : ST_EMPTY;
      end
      return res;
   endfunction

   // Driver: bursts with random gaps; advance on the accepting edge.
   int gap_left = 0;
   int burst_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid)
            expected_status.push_back(queue_predict(req_ch.data));
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= pending_beats.pop_front();
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: stalls on its own pattern, plus one long hold-off.
   int stall_phase = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (long_holdoff)
            rsp_ch.ready <= 1'b0;
         else if (stall_phase[8])
            rsp_ch.ready <= 1'b1;
         else
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Monitor: compare each status beat with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat %p", rsp_ch.data);
         end else begin
            want = expected_status.pop_front();
            if (rsp_ch.data.status !== want.status ||
                rsp_ch.data.out_tag !== want.out_tag ||
                rsp_ch.data.out_priority !== want.out_priority ||
                rsp_ch.data.out_bytes !== want.out_bytes) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p got %p", want, rsp_ch.data);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TimeoutCycles) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_NUM_QUEUES: cfg_nq = value[3:0];
         REG_QLIMIT:     cfg_qlim = value[15:0];
         REG_MEAN:       cfg_mean = value[13:0];
         REG_THRESH:     cfg_thresh = value[15:0];
         default:        cfg_mark = value[1:0];
      endcase
   endtask

   task automatic apply_setting(input logic [3:0] nq, input logic [15:0] qlim,
                                input logic [13:0] mean, input logic [15:0] thr,
                                input logic [1:0] mark);
      csr_write(REG_NUM_QUEUES, nq);
      csr_write(REG_QLIMIT, qlim);
      csr_write(REG_MEAN, mean);
      csr_write(REG_THRESH, thr);
      csr_write(REG_MARKMODE, mark);
   endtask

   // Hold until the bench has no beats in flight, then let the pipe settle.
   task automatic drain_all();
      wait (pending_beats.size() == 0 && !req_ch.valid && expected_status.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_type make_beat(logic op, logic [3:0] prio,
                                         logic [15:0] len, logic [15:0] tag);
      req_type r;
      r.operation = op;
      r.priority_req = prio;
      r.pkt_bytes = len;
      r.pkt_tag = tag;
      return r;
   endfunction

   // Mostly in-range classes and modest sizes, some full-range noise.
   task automatic queue_random(int count, int deq_pct, int max_len);
      logic [3:0]  prio;
      logic [15:0] len;
      for (int i = 0; i < count; i++) begin
         prio = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                            : $urandom_range(0, cfg_nq > 0 ? cfg_nq - 1 : 0);
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, max_len);
         pending_beats.push_back(make_beat($urandom_range(0, 99) < deq_pct, prio,
                                           len, $urandom_range(0, 65535)));
      end
   endtask

   initial begin
      cfg_nq = 8; cfg_qlim = 100; cfg_mean = 1500; cfg_thresh = 16'hFFFF; cfg_mark = 0;
      foreach (class_sum[i]) class_sum[i] = 0;
      port_sum = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset config, extremes, bad class, empty, zero-byte beats.
      pending_beats.push_back(make_beat(OP_DEQ, 0, 0, 0));
      pending_beats.push_back(make_beat(OP_ENQ, 0, 0, 16'hFFFF));
      pending_beats.push_back(make_beat(OP_ENQ, 7, 16'hFFFF, 16'h0000));
      pending_beats.push_back(make_beat(OP_ENQ, 7, 1, 16'hA5A5));
      pending_beats.push_back(make_beat(OP_ENQ, 8, 1, 16'h1234));
      pending_beats.push_back(make_beat(OP_ENQ, 15, 16'hFFFF, 16'h5A5A));
      pending_beats.push_back(make_beat(OP_ENQ, 3, 500, 16'h0F0F));
      pending_beats.push_back(make_beat(OP_ENQ, 0, 16'hFFFF, 16'hF0F0));
      pending_beats.push_back(make_beat(OP_ENQ, 0, 16'hFFFF, 16'h0001));
      pending_beats.push_back(make_beat(OP_ENQ, 0, 16'hFFFF, 16'h0002));
      for (int i = 0; i < 7; i++)
         pending_beats.push_back(make_beat(OP_DEQ, 4'hF, 16'hFFFF, 16'hFFFF));
      drain_all();

      // Marking per class and per port, small mean so both limits bite.
      apply_setting(4, 40, 10, 5, MARK_QUEUE);
      for (int i = 0; i < 4; i++)
         pending_beats.push_back(make_beat(OP_ENQ, 2, 30, i));
      pending_beats.push_back(make_beat(OP_ENQ, 4, 1, 9));
      drain_all();
      csr_write(REG_MARKMODE, MARK_PORT);
      pending_beats.push_back(make_beat(OP_ENQ, 1, 10, 7));
      drain_all();

      // Fill one class past its depth with zero and tiny sizes.
      apply_setting(0, 16'hFFFF, 14'h3FFF, 16'hFFFF, 3);
      for (int i = 0; i < EntriesPerClass + 3; i++)
         pending_beats.push_back(make_beat(OP_ENQ, 0, i % 2, i));
      for (int i = 0; i < EntriesPerClass + 2; i++)
         pending_beats.push_back(make_beat(OP_DEQ, 0, 0, 0));
      drain_all();

      // Long hold-off: receiver stops, sender keeps offering.
      apply_setting(8, 16'hFFFF, 9000, 16'hFFFF, 0);
      queue_random(40, 20, 2000);
      long_holdoff = 1'b1;
      repeat (300) @(posedge clock);
      long_holdoff = 1'b0;
      drain_all();

      // Random phases over several settings, extremes included.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: apply_setting(8, 100, 1500, 16'hFFFF, 0);
            1: apply_setting(1, 1, 1, 0, MARK_QUEUE);
            2: apply_setting(15, 20, 100, 10, MARK_PORT);
            3: apply_setting(3, 16'hFFFF, 9000, 200, MARK_QUEUE);
            4: apply_setting($urandom_range(0, 15), $urandom_range(1, 300),
                             $urandom_range(1, 9000), $urandom_range(0, 65535),
                             $urandom_range(0, 3));
            default: apply_setting(8, 50, 200, 30, MARK_PORT);
         endcase
         queue_random(125, 35, 1500);
         queue_random(125, 55, 1500);
         drain_all();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_status.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

>>> files.f
hdl/spbq_pkg.sv
hdl/spbq_if.sv
hdl/spbq_ctrl.sv
hdl/spbq_dp.sv
hdl/strict_priority_byte_queue_core.sv
hdl/spbq_checker.sv
bench/testbench.sv
